>>> design/cau_pkg.sv
package cau_pkg;

    localparam int DATA_W       = 32;
    localparam int FRAC_W       = 16;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int DIV_W        = PROD_W + FRAC_W;
    localparam int DIV_STEPS    = DIV_W;
    localparam int SQRT_STEPS   = DATA_W;
    localparam int CORDIC_STEPS = 30;
    localparam int CNT_W        = $clog2(DIV_STEPS + 1);
    localparam int CX_W         = DATA_W + 4;
    localparam int CZ_W         = 35;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam logic signed [CZ_W-1:0] PI_Q30 = 35'sd3373259426;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MAG = 3'd4,
        OP_ARG = 3'd5
    } cau_op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_SAT  = 2'd2
    } cau_status_t;

    typedef enum logic [2:0] {
        CLS_ADD,
        CLS_SUB,
        CLS_MUL,
        CLS_DIV,
        CLS_DIVZ,
        CLS_MAG,
        CLS_ARG,
        CLS_ZERO
    } cau_cls_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_SIMPLE,
        BS_MULT,
        BS_SUM,
        BS_DIV,
        BS_SQRT,
        BS_CORDIC,
        BS_FIN
    } cau_state_t;

    typedef struct packed {
        cau_cls_t           cls;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } cau_item_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } cau_sat_t;

    // clamp a sign-magnitude value to the signed result range
    function automatic cau_sat_t sat_sm(input logic neg, input logic [DIV_W-1:0] mag);
        cau_sat_t r;
        r.sat = 1'b0;
        if (!neg) begin
            if (mag > DIV_W'({1'b0, {(DATA_W-1){1'b1}}})) begin
                r.sat = 1'b1;
                r.val = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                r.val = mag[31:0];
            end
        end else begin
            if (mag > DIV_W'({1'b1, {(DATA_W-1){1'b0}}})) begin
                r.sat = 1'b1;
                r.val = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                r.val = -mag[31:0];
            end
        end
        return r;
    endfunction

    // atan(2^-i) in Q30, truncated
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            5'd24:   v = 30'h0000003F;
            5'd25:   v = 30'h0000001F;
            5'd26:   v = 30'h0000000F;
            5'd27:   v = 30'h00000007;
            5'd28:   v = 30'h00000003;
            5'd29:   v = 30'h00000001;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

>>> design/cau_front.sv
module cau_front (
    input  logic                 start,
    input  logic [2:0]           opcode,
    input  logic signed [31:0]   a_re,
    input  logic signed [31:0]   a_im,
    input  logic signed [31:0]   b_re,
    input  logic signed [31:0]   b_im,
    input  logic                 full,
    output logic                 busy,
    output logic                 push,
    output cau_pkg::cau_item_t   item
);

    logic b_zero;
    logic a_zero;

    assign busy   = full;
    assign push   = start && !full;
    assign b_zero = (b_re == '0) && (b_im == '0);
    assign a_zero = (a_re == '0) && (a_im == '0);

    always_comb
    begin
        item.a_re = a_re;
        item.a_im = a_im;
        item.b_re = b_re;
        item.b_im = b_im;
        case (opcode)
            cau_pkg::OP_ADD: item.cls = cau_pkg::CLS_ADD;
            cau_pkg::OP_SUB: item.cls = cau_pkg::CLS_SUB;
            cau_pkg::OP_MUL: item.cls = cau_pkg::CLS_MUL;
            cau_pkg::OP_DIV: item.cls = b_zero ? cau_pkg::CLS_DIVZ : cau_pkg::CLS_DIV;
            cau_pkg::OP_MAG: item.cls = cau_pkg::CLS_MAG;
            cau_pkg::OP_ARG: item.cls = a_zero ? cau_pkg::CLS_ZERO : cau_pkg::CLS_ARG;
            default:         item.cls = cau_pkg::CLS_ZERO;
        endcase
    end

endmodule

>>> design/cau_fifo.sv
module cau_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cau_pkg::cau_item_t   wr_item,
    input  logic                 pop,
    output cau_pkg::cau_item_t   rd_item,
    output logic                 full,
    output logic                 empty
);

    cau_pkg::cau_item_t               mem_reg [cau_pkg::FIFO_DEPTH];
    logic [cau_pkg::FIFO_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [cau_pkg::FIFO_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [cau_pkg::FIFO_AW:0]        count_reg, count_next;

    assign full    = (count_reg == (cau_pkg::FIFO_AW+1)'(cau_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

>>> design/cau_back.sv
module cau_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  cau_pkg::cau_item_t   head,
    output logic                 pop,
    output logic                 done,
    output logic signed [31:0]   result_re,
    output logic signed [31:0]   result_im,
    output logic [1:0]           status
);

    localparam int DW = cau_pkg::DIV_W;
    localparam int PW = cau_pkg::PROD_W;
    localparam int XW = cau_pkg::CX_W;
    localparam int ZW = cau_pkg::CZ_W;
    localparam int CW = cau_pkg::CNT_W;

    cau_pkg::cau_state_t state_reg, state_next;
    cau_pkg::cau_cls_t   cls_reg, cls_next;

    logic signed [31:0]  ar_reg, ar_next, ai_reg, ai_next;
    logic signed [31:0]  br_reg, br_next, bi_reg, bi_next;
    logic [2:0]          k_reg, k_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic signed [PW-1:0] prod_reg [6];
    logic signed [PW-1:0] prod;
    logic signed [31:0]  m_a, m_b;
    logic [2:0]          k_last;

    logic [DW-1:0]       dq_re_reg, dq_re_next, dq_im_reg, dq_im_next;
    logic [PW-1:0]       dr_re_reg, dr_re_next, dr_im_reg, dr_im_next;
    logic                neg_re_reg, neg_re_next, neg_im_reg, neg_im_next;
    logic [PW-1:0]       den_reg, den_next;

    logic [PW-1:0]       sq_n_reg, sq_n_next;
    logic [31:0]         root_reg, root_next;
    logic [33:0]         rem_reg, rem_next;

    logic signed [XW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ZW-1:0] cz_reg, cz_next;

    logic signed [31:0]  res_re_reg, res_re_next, res_im_reg, res_im_next;
    logic [1:0]          status_reg, status_next;
    logic                done_reg, done_next;

    // combinational helpers
    logic signed [32:0]  s33_re, s33_im;
    logic [32:0]         m33_re, m33_im;
    logic signed [PW:0]  s_re, s_im;
    logic [PW:0]         m_re, m_im;
    logic [PW:0]         r2_re, r2_im;
    logic [35:0]         rem2, trial;
    logic signed [XW-1:0] sh_x, sh_y;
    logic signed [ZW-1:0] atan_v, zr;
    logic [ZW-1:0]       zmag;
    logic signed [XW-1:0] ix, iy;
    cau_pkg::cau_sat_t   sr, si;

    assign pop       = (state_reg == cau_pkg::BS_IDLE) && !empty;
    assign done      = done_reg;
    assign result_re = res_re_reg;
    assign result_im = res_im_reg;
    assign status    = status_reg;

    // shared multiplier operand select
    always_comb
    begin
        case (k_reg)
            3'd0:    begin m_a = ar_reg; m_b = (cls_reg == cau_pkg::CLS_MAG) ? ar_reg : br_reg; end
            3'd1:    begin m_a = ai_reg; m_b = (cls_reg == cau_pkg::CLS_MAG) ? ai_reg : bi_reg; end
            3'd2:    begin m_a = ar_reg; m_b = bi_reg; end
            3'd3:    begin m_a = ai_reg; m_b = br_reg; end
            3'd4:    begin m_a = br_reg; m_b = br_reg; end
            3'd5:    begin m_a = bi_reg; m_b = bi_reg; end
            default: begin m_a = '0;     m_b = '0;     end
        endcase
        case (cls_reg)
            cau_pkg::CLS_MUL: k_last = 3'd3;
            cau_pkg::CLS_DIV: k_last = 3'd5;
            default:          k_last = 3'd1;
        endcase
    end

    assign prod = m_a * m_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cau_pkg::BS_IDLE:
            begin
                if (!empty)
                begin
                    case (head.cls)
                        cau_pkg::CLS_MUL, cau_pkg::CLS_DIV, cau_pkg::CLS_MAG:
                            state_next = cau_pkg::BS_MULT;
                        cau_pkg::CLS_ARG:
                            state_next = cau_pkg::BS_CORDIC;
                        default:
                            state_next = cau_pkg::BS_SIMPLE;
                    endcase
                end
            end
            cau_pkg::BS_SIMPLE: state_next = cau_pkg::BS_IDLE;
            cau_pkg::BS_MULT:
            begin
                if (k_reg == k_last)
                begin
                    state_next = cau_pkg::BS_SUM;
                end
            end
            cau_pkg::BS_SUM:
            begin
                case (cls_reg)
                    cau_pkg::CLS_DIV: state_next = cau_pkg::BS_DIV;
                    cau_pkg::CLS_MAG: state_next = cau_pkg::BS_SQRT;
                    default:          state_next = cau_pkg::BS_IDLE;
                endcase
            end
            cau_pkg::BS_DIV:
            begin
                if (cnt_reg == CW'(cau_pkg::DIV_STEPS - 1))
                begin
                    state_next = cau_pkg::BS_FIN;
                end
            end
            cau_pkg::BS_SQRT:
            begin
                if (cnt_reg == CW'(cau_pkg::SQRT_STEPS - 1))
                begin
                    state_next = cau_pkg::BS_FIN;
                end
            end
            cau_pkg::BS_CORDIC:
            begin
                if (cnt_reg == CW'(cau_pkg::CORDIC_STEPS - 1))
                begin
                    state_next = cau_pkg::BS_FIN;
                end
            end
            cau_pkg::BS_FIN: state_next = cau_pkg::BS_IDLE;
            default:         state_next = cau_pkg::BS_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cls_next    = cls_reg;
        ar_next     = ar_reg;
        ai_next     = ai_reg;
        br_next     = br_reg;
        bi_next     = bi_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        dq_re_next  = dq_re_reg;
        dq_im_next  = dq_im_reg;
        dr_re_next  = dr_re_reg;
        dr_im_next  = dr_im_reg;
        neg_re_next = neg_re_reg;
        neg_im_next = neg_im_reg;
        den_next    = den_reg;
        sq_n_next   = sq_n_reg;
        root_next   = root_reg;
        rem_next    = rem_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cz_next     = cz_reg;
        res_re_next = res_re_reg;
        res_im_next = res_im_reg;
        status_next = status_reg;
        done_next   = 1'b0;

        s33_re = '0;
        s33_im = '0;
        case (cls_reg)
            cau_pkg::CLS_ADD:
            begin
                s33_re = {ar_reg[31], ar_reg} + {br_reg[31], br_reg};
                s33_im = {ai_reg[31], ai_reg} + {bi_reg[31], bi_reg};
            end
            cau_pkg::CLS_SUB:
            begin
                s33_re = {ar_reg[31], ar_reg} - {br_reg[31], br_reg};
                s33_im = {ai_reg[31], ai_reg} - {bi_reg[31], bi_reg};
            end
            default:
            begin
                s33_re = '0;
                s33_im = '0;
            end
        endcase
        m33_re = s33_re[32] ? 33'(-s33_re) : 33'(s33_re);
        m33_im = s33_im[32] ? 33'(-s33_im) : 33'(s33_im);

        if (cls_reg == cau_pkg::CLS_DIV)
        begin
            s_re = {prod_reg[0][PW-1], prod_reg[0]} + {prod_reg[1][PW-1], prod_reg[1]};
            s_im = {prod_reg[3][PW-1], prod_reg[3]} - {prod_reg[2][PW-1], prod_reg[2]};
        end
        else
        begin
            s_re = {prod_reg[0][PW-1], prod_reg[0]} - {prod_reg[1][PW-1], prod_reg[1]};
            s_im = {prod_reg[2][PW-1], prod_reg[2]} + {prod_reg[3][PW-1], prod_reg[3]};
        end
        m_re = s_re[PW] ? (PW+1)'(-s_re) : (PW+1)'(s_re);
        m_im = s_im[PW] ? (PW+1)'(-s_im) : (PW+1)'(s_im);

        // one restoring division step for each part
        r2_re = {dr_re_reg, dq_re_reg[DW-1]};
        r2_im = {dr_im_reg, dq_im_reg[DW-1]};

        // one digit of the square root
        rem2  = {rem_reg, sq_n_reg[PW-1:PW-2]};
        trial = {2'b00, root_reg, 2'b01};

        sh_x   = cx_reg >>> cnt_reg[4:0];
        sh_y   = cy_reg >>> cnt_reg[4:0];
        atan_v = ZW'(cau_pkg::atan_q30(cnt_reg[4:0]));
        zr     = (cz_reg + ZW'(1 << (29 - cau_pkg::FRAC_W))) >>> (30 - cau_pkg::FRAC_W);
        zmag   = zr[ZW-1] ? ZW'(-zr) : ZW'(zr);

        ix = XW'(head.a_re);
        iy = XW'(head.a_im);

        sr = cau_pkg::sat_sm(1'b0, '0);
        si = cau_pkg::sat_sm(1'b0, '0);

        case (state_reg)
            cau_pkg::BS_IDLE:
            begin
                if (!empty)
                begin
                    cls_next = head.cls;
                    ar_next  = head.a_re;
                    ai_next  = head.a_im;
                    br_next  = head.b_re;
                    bi_next  = head.b_im;
                    k_next   = '0;
                    cnt_next = '0;
                    // fold the left half plane over before rotating
                    if (ix < 0)
                    begin
                        cx_next = -ix;
                        cy_next = -iy;
                        cz_next = (iy >= 0) ? cau_pkg::PI_Q30 : -cau_pkg::PI_Q30;
                    end
                    else
                    begin
                        cx_next = ix;
                        cy_next = iy;
                        cz_next = '0;
                    end
                end
            end
            cau_pkg::BS_SIMPLE:
            begin
                sr = cau_pkg::sat_sm(s33_re[32], DW'(m33_re));
                si = cau_pkg::sat_sm(s33_im[32], DW'(m33_im));
                done_next = 1'b1;
                case (cls_reg)
                    cau_pkg::CLS_ADD, cau_pkg::CLS_SUB:
                    begin
                        res_re_next = sr.val;
                        res_im_next = si.val;
                        status_next = (sr.sat || si.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
                    end
                    cau_pkg::CLS_DIVZ:
                    begin
                        res_re_next = '0;
                        res_im_next = '0;
                        status_next = cau_pkg::ST_DIVZ;
                    end
                    default:
                    begin
                        res_re_next = '0;
                        res_im_next = '0;
                        status_next = cau_pkg::ST_OK;
                    end
                endcase
            end
            cau_pkg::BS_MULT:
            begin
                k_next = k_reg + 1'b1;
            end
            cau_pkg::BS_SUM:
            begin
                cnt_next = '0;
                case (cls_reg)
                    cau_pkg::CLS_MUL:
                    begin
                        sr = cau_pkg::sat_sm(s_re[PW], DW'(m_re >> cau_pkg::FRAC_W));
                        si = cau_pkg::sat_sm(s_im[PW], DW'(m_im >> cau_pkg::FRAC_W));
                        res_re_next = sr.val;
                        res_im_next = si.val;
                        status_next = (sr.sat || si.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
                        done_next   = 1'b1;
                    end
                    cau_pkg::CLS_DIV:
                    begin
                        neg_re_next = s_re[PW];
                        neg_im_next = s_im[PW];
                        dq_re_next  = {m_re[PW-1:0], {cau_pkg::FRAC_W{1'b0}}};
                        dq_im_next  = {m_im[PW-1:0], {cau_pkg::FRAC_W{1'b0}}};
                        dr_re_next  = '0;
                        dr_im_next  = '0;
                        den_next    = prod_reg[4] + prod_reg[5];
                    end
                    default:
                    begin
                        sq_n_next = prod_reg[0] + prod_reg[1];
                        root_next = '0;
                        rem_next  = '0;
                    end
                endcase
            end
            cau_pkg::BS_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (r2_re >= {1'b0, den_reg})
                begin
                    dr_re_next = PW'(r2_re - {1'b0, den_reg});
                    dq_re_next = {dq_re_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    dr_re_next = r2_re[PW-1:0];
                    dq_re_next = {dq_re_reg[DW-2:0], 1'b0};
                end
                if (r2_im >= {1'b0, den_reg})
                begin
                    dr_im_next = PW'(r2_im - {1'b0, den_reg});
                    dq_im_next = {dq_im_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    dr_im_next = r2_im[PW-1:0];
                    dq_im_next = {dq_im_reg[DW-2:0], 1'b0};
                end
            end
            cau_pkg::BS_SQRT:
            begin
                cnt_next  = cnt_reg + 1'b1;
                sq_n_next = {sq_n_reg[PW-3:0], 2'b00};
                if (rem2 >= trial)
                begin
                    rem_next  = 34'(rem2 - trial);
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem2[33:0];
                    root_next = {root_reg[30:0], 1'b0};
                end
            end
            cau_pkg::BS_CORDIC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cy_reg > 0)
                begin
                    cx_next = cx_reg + sh_y;
                    cy_next = cy_reg - sh_x;
                    cz_next = cz_reg + atan_v;
                end
                else
                begin
                    cx_next = cx_reg - sh_y;
                    cy_next = cy_reg + sh_x;
                    cz_next = cz_reg - atan_v;
                end
            end
            cau_pkg::BS_FIN:
            begin
                done_next   = 1'b1;
                res_im_next = '0;
                case (cls_reg)
                    cau_pkg::CLS_DIV:
                    begin
                        sr = cau_pkg::sat_sm(neg_re_reg, dq_re_reg);
                        si = cau_pkg::sat_sm(neg_im_reg, dq_im_reg);
                        res_im_next = si.val;
                    end
                    cau_pkg::CLS_MAG:
                        sr = cau_pkg::sat_sm(1'b0, DW'(root_reg));
                    default:
                        sr = cau_pkg::sat_sm(zr[ZW-1], DW'(zmag));
                endcase
                res_re_next = sr.val;
                status_next = (sr.sat || si.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cau_pkg::BS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg    <= cls_next;
        ar_reg     <= ar_next;
        ai_reg     <= ai_next;
        br_reg     <= br_next;
        bi_reg     <= bi_next;
        k_reg      <= k_next;
        cnt_reg    <= cnt_next;
        dq_re_reg  <= dq_re_next;
        dq_im_reg  <= dq_im_next;
        dr_re_reg  <= dr_re_next;
        dr_im_reg  <= dr_im_next;
        neg_re_reg <= neg_re_next;
        neg_im_reg <= neg_im_next;
        den_reg    <= den_next;
        sq_n_reg   <= sq_n_next;
        root_reg   <= root_next;
        rem_reg    <= rem_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        res_re_reg <= res_re_next;
        res_im_reg <= res_im_next;
        status_reg <= status_next;
        if (state_reg == cau_pkg::BS_MULT)
        begin
            prod_reg[k_reg] <= prod;
        end
    end

endmodule

>>> design/complex_arith_unit.sv
// Complex arithmetic unit on signed Q16.16 operands.
// Input: drive opcode, a_re, a_im, b_re, b_im with start high; the item is
// taken at a clock edge where start is high and busy is low. busy rises only
// when the four-entry queue between the decoder and the execution engine is
// full, so items are taken while earlier ones are still being worked.
// Output: each result appears on result_re, result_im and status for one
// cycle with done high. The receiver cannot stall; results are never held.
// The engine works one item at a time on a shared 32x32 multiplier, a
// bit-serial divider, a digit-serial square root and a CORDIC rotator.
// add, sub, unknown opcode, divide by zero and angle of zero use only the
// simple state; mul uses the multiplier, mag also the root, arg CORDIC, div
// the multiplier and divider (two quotients, one bit each per cycle).
// The engine takes a new item only after finishing the last one; its
// occupancy is set by the iteration count of the unit each opcode uses.
// Reset empties the queue and returns the engine to idle; an item in flight
// is lost and no result is given for it.
module complex_arith_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           opcode,
    input  logic signed [31:0]   a_re,
    input  logic signed [31:0]   a_im,
    input  logic signed [31:0]   b_re,
    input  logic signed [31:0]   b_im,
    output logic                 done,
    output logic signed [31:0]   result_re,
    output logic signed [31:0]   result_im,
    output logic [1:0]           status
);

    cau_pkg::cau_item_t in_item;
    cau_pkg::cau_item_t head_item;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;

    cau_front u_front (
        .start  (start),
        .opcode (opcode),
        .a_re   (a_re),
        .a_im   (a_im),
        .b_re   (b_re),
        .b_im   (b_im),
        .full   (full),
        .busy   (busy),
        .push   (push),
        .item   (in_item)
    );

    cau_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (in_item),
        .pop     (pop),
        .rd_item (head_item),
        .full    (full),
        .empty   (empty)
    );

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head_item),
        .pop       (pop),
        .done      (done),
        .result_re (result_re),
        .result_im (result_im),
        .status    (status)
    );

endmodule

>>> design/cau_checker.sv
module cau_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 done,
    input  logic signed [31:0]   result_re,
    input  logic signed [31:0]   result_im,
    input  logic [1:0]           status
);

    logic re_lim;
    logic im_lim;

    assign re_lim = (result_re == 32'sh7FFFFFFF) || (result_re == 32'sh80000000);
    assign im_lim = (result_im == 32'sh7FFFFFFF) || (result_im == 32'sh80000000);

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status != 2'd3))
        else $error("status code out of range");

    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cau_pkg::ST_DIVZ) |-> (result_re == '0 && result_im == '0))
        else $error("divide by zero result not cleared");

    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cau_pkg::ST_SAT) |-> (re_lim || im_lim))
        else $error("saturated status without a clamped field");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !done)
        else $error("result strobe right after reset");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .done      (done),
    .result_re (result_re),
    .result_im (result_im),
    .status    (status)
);
